// File: hw/rtl/lcoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcoc_pkg
// Shared types, register codes and the sRGB linearization table.
// ----------------------------------------------------------------------------
package lcoc_pkg;

	localparam int CHAN_W   = 8;
	localparam int LIN_W    = 17;   // Q0.16, 1.0 (white) needs the 17th bit
	localparam int THR_W    = 16;
	localparam int FACTOR_W = 9;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESHOLD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FACTOR    = 8'd1;

	localparam logic [THR_W-1:0]    THRESHOLD_RESET = 16'd26214;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET    = 9'd0;

	// luminance weights, Q0.16, they sum to 65536
	localparam int COEF_W = 16;
	localparam logic [COEF_W-1:0] COEF_RED   = 16'd13933;
	localparam logic [COEF_W-1:0] COEF_GREEN = 16'd46871;
	localparam logic [COEF_W-1:0] COEF_BLUE  = 16'd4732;
	localparam int PROD_W = LIN_W + COEF_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic [CHAN_W-1:0] GRAY_BRIGHT      = 8'd10;
	localparam logic [CHAN_W-1:0] GRAY_BRIGHT_SOFT = 8'd30;
	localparam logic [CHAN_W-1:0] GRAY_DARK        = 8'd255;
	localparam logic [CHAN_W-1:0] GRAY_DARK_SOFT   = 8'd200;
	localparam logic [CHAN_W-1:0] CHAN_MAX         = 8'd255;

	// linear segment: c <= 10, floor((1310720*c + 32946) / 65892)
	localparam int LIN_KNEE     = 10;
	localparam int LIN_LOW_MUL  = 1310720;
	localparam int LIN_LOW_BIAS = 32946;
	localparam int LIN_LOW_DIV  = 65892;

	typedef logic [255:0][LIN_W-1:0] lin_tab_t;

	// Lane control, shared by the three channel lanes.
	typedef struct packed {
		logic en;       // pipeline advances this cycle
		logic bright;   // classification of the item in stage 3
	} lane_ctl_t;

	// Worked out at elaboration only. Power segment rounds ties down.
	function automatic lin_tab_t build_lin_table();
		lin_tab_t tab;
		real u;
		real v;
		int k;
		for (int c = 0; c < 256; c++) begin
			if (c <= LIN_KNEE) begin
				k = (c * LIN_LOW_MUL + LIN_LOW_BIAS) / LIN_LOW_DIV;
			end else begin
				u = (40.0 * c + 561.0) / 10761.0;
				v = 65536.0 * (u ** 2.4);
				k = int'($ceil(v - 0.5));
			end
			tab[c] = k[LIN_W-1:0];
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

// File: hw/rtl/lcoc_offset_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcoc_offset_lane
// One color channel: darkened and lightened candidates, picked by brightness.
// ----------------------------------------------------------------------------
module lcoc_offset_lane (
	input  logic                            clk,
	input  lcoc_pkg::lane_ctl_t             ctl,
	input  logic [lcoc_pkg::CHAN_W-1:0]     chan,
	input  logic [lcoc_pkg::FACTOR_W-1:0]   factor,
	output logic [lcoc_pkg::CHAN_W-1:0]     result
);

	localparam int MUL_W = lcoc_pkg::CHAN_W + lcoc_pkg::FACTOR_W;

	logic [lcoc_pkg::CHAN_W-1:0] chan_s1, chan_s2;
	logic [MUL_W-1:0]            dk_prod_s2, lt_prod_s2;
	logic [lcoc_pkg::CHAN_W-1:0] dark_s3, light_s3;
	logic [lcoc_pkg::CHAN_W-1:0] result_q;

	logic [MUL_W-1:0]            dk_round, lt_round;
	logic [MUL_W-9:0]            dk_step, lt_step;
	logic [MUL_W-8:0]            lt_sum;
	logic [lcoc_pkg::CHAN_W-1:0] dark_c, light_c;

	always_comb begin
		dk_round = dk_prod_s2 + MUL_W'(128);
		lt_round = lt_prod_s2 + MUL_W'(128);
		dk_step  = dk_round[MUL_W-1:8];
		lt_step  = lt_round[MUL_W-1:8];
		// floor at zero
		if ({1'b0, chan_s2} > dk_step) begin
			dark_c = chan_s2 - dk_step[lcoc_pkg::CHAN_W-1:0];
		end else begin
			dark_c = '0;
		end
		// cap at full scale
		lt_sum = {1'b0, lt_step} + (MUL_W-7)'(chan_s2);
		if (lt_sum > (MUL_W-7)'(lcoc_pkg::CHAN_MAX)) begin
			light_c = lcoc_pkg::CHAN_MAX;
		end else begin
			light_c = lt_sum[lcoc_pkg::CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			chan_s1    <= chan;
			chan_s2    <= chan_s1;
			dk_prod_s2 <= MUL_W'(chan_s1) * MUL_W'(factor);
			lt_prod_s2 <= MUL_W'(lcoc_pkg::CHAN_MAX - chan_s1) * MUL_W'(factor);
			dark_s3    <= dark_c;
			light_s3   <= light_c;
			result_q   <= ctl.bright ? dark_s3 : light_s3;
		end
	end

	assign result = result_q;

endmodule

// File: hw/rtl/luminance_contrast_offset_color_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luminance_contrast_offset_color_core
// Relative luminance classifier with offset color and contrast gray level.
// ----------------------------------------------------------------------------
// Path: an accepted pixel moves through stages 1, 2 and 3, then the output stage.
// Throughput: one pixel per clock when not stalled; four register stages (input +
//   lookup, weight multiply, sum/compare, output) advance together on one enable.
// Reset: arst_n clears all valid bits and loads threshold 26214 and factor 0;
//   the linearization table is a constant and needs no fill.
// ----------------------------------------------------------------------------
module luminance_contrast_offset_color_core (
	input  logic                              clk,
	input  logic                              arst_n,

	// pixel input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lcoc_pkg::CHAN_W-1:0]       red,
	input  logic [lcoc_pkg::CHAN_W-1:0]       green,
	input  logic [lcoc_pkg::CHAN_W-1:0]       blue,
	input  logic                              softer,

	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              is_bright,
	output logic [lcoc_pkg::CHAN_W-1:0]       offset_red,
	output logic [lcoc_pkg::CHAN_W-1:0]       offset_green,
	output logic [lcoc_pkg::CHAN_W-1:0]       offset_blue,
	output logic [lcoc_pkg::CHAN_W-1:0]       contrast_gray,

	// register write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lcoc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcoc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// ---- configuration registers --------------------------------------
	logic [lcoc_pkg::THR_W-1:0]    threshold_q;
	logic [lcoc_pkg::FACTOR_W-1:0] factor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= lcoc_pkg::THRESHOLD_RESET;
			factor_q    <= lcoc_pkg::FACTOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			// indexes past the list are dropped
			if (cfg_index == lcoc_pkg::REG_BRIGHT_THRESHOLD) begin
				threshold_q <= cfg_data[lcoc_pkg::THR_W-1:0];
			end
			if (cfg_index == lcoc_pkg::REG_OFFSET_FACTOR) begin
				factor_q <= cfg_data[lcoc_pkg::FACTOR_W-1:0];
			end
		end
	end

	// ---- pipeline enable ------------------------------------------------
	// Whole pipe moves as one; it holds only when a finished beat waits at
	// the output and the receiver stalls. Bubbles fill behind it meanwhile
	// are not squeezed out, but nothing is lost or repeated.
	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_q;

	assign en       = !(valid_q && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_q  <= valid_s3;
		end
	end

	// ---- stage 1: table lookup on the incoming beat ------------------------
	logic [lcoc_pkg::LIN_W-1:0] lin_r_s1, lin_g_s1, lin_b_s1;
	logic                       softer_s1, softer_s2, softer_s3;

	// ---- stage 2: weighted linear channels ----------------------------------
	logic [lcoc_pkg::PROD_W-1:0] prod_r_s2, prod_g_s2, prod_b_s2;

	// ---- stage 3: luminance sum and threshold compare ----------------------
	logic [lcoc_pkg::SUM_W-1:0]   lum_sum;
	logic [lcoc_pkg::SUM_W-17:0]  lum;      // 0..65536
	logic                         bright_s3;

	always_comb begin
		lum_sum = lcoc_pkg::SUM_W'(prod_r_s2) + lcoc_pkg::SUM_W'(prod_g_s2)
			+ lcoc_pkg::SUM_W'(prod_b_s2);
		lum = lum_sum[lcoc_pkg::SUM_W-1:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_r_s1  <= lcoc_pkg::LIN_TABLE[red];
			lin_g_s1  <= lcoc_pkg::LIN_TABLE[green];
			lin_b_s1  <= lcoc_pkg::LIN_TABLE[blue];
			softer_s1 <= softer;

			prod_r_s2 <= lcoc_pkg::PROD_W'(lin_r_s1) * lcoc_pkg::PROD_W'(lcoc_pkg::COEF_RED);
			prod_g_s2 <= lcoc_pkg::PROD_W'(lin_g_s1) * lcoc_pkg::PROD_W'(lcoc_pkg::COEF_GREEN);
			prod_b_s2 <= lcoc_pkg::PROD_W'(lin_b_s1) * lcoc_pkg::PROD_W'(lcoc_pkg::COEF_BLUE);
			softer_s2 <= softer_s1;

			// strictly above; white (65536) beats any threshold
			bright_s3 <= lum > (lcoc_pkg::SUM_W-16)'(threshold_q);
			softer_s3 <= softer_s2;
		end
	end

	// ---- output stage: contrast gray ----------------------------------------
	logic                        bright_q;
	logic [lcoc_pkg::CHAN_W-1:0] gray_q;

	always_ff @(posedge clk) begin
		if (en) begin
			bright_q <= bright_s3;
			if (bright_s3) begin
				gray_q <= softer_s3 ? lcoc_pkg::GRAY_BRIGHT_SOFT : lcoc_pkg::GRAY_BRIGHT;
			end else begin
				gray_q <= softer_s3 ? lcoc_pkg::GRAY_DARK_SOFT : lcoc_pkg::GRAY_DARK;
			end
		end
	end

	// ---- offset color lanes, aligned with the stages above -----------------
	lcoc_pkg::lane_ctl_t lane_ctl;

	assign lane_ctl.en     = en;
	assign lane_ctl.bright = bright_s3;

	lcoc_offset_lane u_lane_red (
		.clk    (clk),
		.ctl    (lane_ctl),
		.chan   (red),
		.factor (factor_q),
		.result (offset_red)
	);

	lcoc_offset_lane u_lane_green (
		.clk    (clk),
		.ctl    (lane_ctl),
		.chan   (green),
		.factor (factor_q),
		.result (offset_green)
	);

	lcoc_offset_lane u_lane_blue (
		.clk    (clk),
		.ctl    (lane_ctl),
		.chan   (blue),
		.factor (factor_q),
		.result (offset_blue)
	);

	assign out_valid     = valid_q;
	assign is_bright     = bright_q;
	assign contrast_gray = gray_q;

	// ---- checks ------------------------------------------------------------
	a_gray_bright: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_bright |->
			(contrast_gray == lcoc_pkg::GRAY_BRIGHT) ||
			(contrast_gray == lcoc_pkg::GRAY_BRIGHT_SOFT))
		else $error("bright beat with a dark gray level");

	a_gray_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_bright |->
			(contrast_gray == lcoc_pkg::GRAY_DARK) ||
			(contrast_gray == lcoc_pkg::GRAY_DARK_SOFT))
		else $error("dark beat with a bright gray level");

	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && en |=> out_valid)
		else $error("beat lost between stage 3 and output");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s1) && $stable(valid_s2) && $stable(valid_s3))
		else $error("pipeline moved while output was stalled");

endmodule
